FILE: hdl/wssd_pkg.sv
// ----------------------------------------------------------------------------
// wssd_pkg: shared definitions of the windowed steady-state detector
// Window geometry, sampling interval, fixed-point widths, register indexes,
// register reset values and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package wssd_pkg;

	localparam int WINDOW_LEN      = 30;
	localparam int SAMPLE_INTERVAL = 100;

	localparam int DATA_W     = 32;
	localparam int TOL_W      = 24;
	localparam int FLOOR_W    = 31;
	localparam int FRAC_SHIFT = 24;

	localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W  = DATA_W + $clog2(WINDOW_LEN);
	localparam int MAG_W  = SUM_W;
	localparam int CMP_W  = MAG_W + TOL_W;

	localparam int MUL_A_W  = DATA_W + 1;
	localparam int PROD_W   = 2 * DATA_W + 1;
	localparam int DEN_LO_W = 18;
	localparam int DEN_HI_W = MAG_W - DEN_LO_W;

	localparam int R_W       = $clog2(SAMPLE_INTERVAL + 1);
	localparam int T_W       = R_W + 2;
	localparam int MOD_STEPS = DATA_W / 2;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS);

	localparam logic [T_W-1:0] SI_X1 = T_W'(SAMPLE_INTERVAL);
	localparam logic [T_W-1:0] SI_X2 = T_W'(2 * SAMPLE_INTERVAL);
	localparam logic [T_W-1:0] SI_X3 = T_W'(3 * SAMPLE_INTERVAL);

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_CD_SCALE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_REL_TOL   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_AVG_FLOOR = CFG_IDX_W'(2);

	localparam logic [DATA_W-1:0]  CD_SCALE_RST  = 32'd16777216;
	localparam logic [TOL_W-1:0]   REL_TOL_RST   = 24'd16777;
	localparam logic [FLOOR_W-1:0] AVG_FLOOR_RST = 31'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOD,
		ST_SAT,
		ST_SCAN,
		ST_SPAN,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_CMP,
		ST_RESULT
	} wssd_state_t;

endpackage

`default_nettype wire

FILE: hdl/wssd_if.sv
// ----------------------------------------------------------------------------
// wssd_if: request channels of the windowed steady-state detector
// Sample channel (step number and force sum) and result channel
// (steady flag, sample taken, drag coefficient), valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wssd_sample_if;
	logic                                valid;
	logic                                ready;
	logic        [wssd_pkg::DATA_W-1:0] step_number;
	logic signed [wssd_pkg::DATA_W-1:0] drag_force_sum;

	modport source (output valid, output step_number, output drag_force_sum, input ready);
	modport sink (input valid, input step_number, input drag_force_sum, output ready);
endinterface

interface wssd_result_if;
	logic                                valid;
	logic                                ready;
	logic                                steady_flag;
	logic                                sample_taken;
	logic signed [wssd_pkg::DATA_W-1:0] drag_coeff;

	modport source (output valid, output steady_flag, output sample_taken, output drag_coeff,
		input ready);
	modport sink (input valid, input steady_flag, input sample_taken, input drag_coeff,
		output ready);
endinterface

`default_nettype wire

FILE: hdl/windowed_steady_state_detector_unit.sv
// ----------------------------------------------------------------------------
// windowed_steady_state_detector_unit: windowed steady-state detector
// Scales force samples into drag coefficients, keeps a ring of recent
// samples and latches steady state once the window span is small enough.
//
// Channels: sample (step_number, drag_force_sum) in, result (steady_flag,
// sample_taken, drag_coeff) out, both valid/ready; one result per request.
// Configuration: cfg_we/cfg_idx/cfg_data write cd_scale (0), rel_tolerance
// (1) and avg_floor (2); other indexes are ignored.
// One request is handled at a time. A request runs through the states MOD,
// SAT and RESULT; when its sample is taken and the ring is then full, the
// window test (SCAN, SPAN, MUL_LO, MUL_HI, CMP) runs between SAT and RESULT.
// The step remainder is formed two bits per cycle; the window test reads
// the ring one entry per cycle through its single read port and reuses the
// one 33x32 multiplier for the tolerance product.
// Reset clears the ring pointer, fill and steady flags and loads register
// defaults; ring contents stay unknown until written.
// A stalled result is held in the output register; the next request is
// still taken, and its result waits until the held one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_steady_state_detector_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	wssd_sample_if.sink                         sample,
	wssd_result_if.source                       result,
	input  wire                                 cfg_we,
	input  wire [wssd_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire [wssd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	wssd_pkg::wssd_state_t state_q, state_d;

	logic        [wssd_pkg::DATA_W-1:0]    cd_scale_q;
	logic        [wssd_pkg::TOL_W-1:0]     rel_tol_q;
	logic        [wssd_pkg::FLOOR_W-1:0]   avg_floor_q;

	logic        [wssd_pkg::DATA_W-1:0]    step_q;
	logic signed [wssd_pkg::DATA_W-1:0]    force_q;
	logic        [wssd_pkg::R_W-1:0]       rem_q;
	logic        [wssd_pkg::MOD_CNT_W-1:0] mod_cnt_q;
	logic signed [wssd_pkg::PROD_W-1:0]    prod_q;
	logic signed [wssd_pkg::DATA_W-1:0]    cd_q;
	logic                                   taken_q;

	logic        [wssd_pkg::SLOT_W-1:0]    slot_q;
	logic                                   filled_q;
	logic                                   steady_q;

	logic        [wssd_pkg::CNT_W-1:0]     scan_cnt_q;
	logic signed [wssd_pkg::DATA_W-1:0]    rd_data_s1;
	logic signed [wssd_pkg::DATA_W-1:0]    lo_q, hi_q;
	logic signed [wssd_pkg::SUM_W-1:0]     sum_q;
	logic        [wssd_pkg::CMP_W-1:0]     lhs_q;
	logic        [wssd_pkg::MAG_W-1:0]     denom_q;
	logic        [wssd_pkg::CMP_W-1:0]     rhs_q;

	logic                                   res_valid_q;
	logic                                   res_steady_q;
	logic                                   res_taken_q;
	logic signed [wssd_pkg::DATA_W-1:0]    res_cd_q;

	logic signed [wssd_pkg::DATA_W-1:0]    ring [wssd_pkg::WINDOW_LEN];

	logic                                   accept;
	logic                                   take;
	logic                                   ring_re;
	logic                                   load_res;
	logic        [wssd_pkg::T_W-1:0]       mod_t;
	logic        [wssd_pkg::R_W-1:0]       rem_d;
	logic signed [wssd_pkg::MUL_A_W-1:0]   mul_a;
	logic        [wssd_pkg::DATA_W-1:0]    mul_b;
	logic signed [2*wssd_pkg::MUL_A_W-1:0] mul_p;
	logic signed [wssd_pkg::PROD_W-wssd_pkg::FRAC_SHIFT-1:0] shifted;
	logic signed [wssd_pkg::DATA_W-1:0]    cd_d;
	logic signed [wssd_pkg::DATA_W-1:0]    scan_lo, scan_hi;
	logic signed [wssd_pkg::DATA_W:0]      span_ext;
	logic        [wssd_pkg::SUM_W-1:0]     span_wl;
	logic        [wssd_pkg::MAG_W-1:0]     mag;
	logic        [wssd_pkg::MAG_W-1:0]     floor_tot;

	assign accept   = sample.valid && sample.ready;
	assign take     = !steady_q && (rem_q == '0);
	assign ring_re  = (state_q == wssd_pkg::ST_SCAN) &&
		(scan_cnt_q < wssd_pkg::CNT_W'(wssd_pkg::WINDOW_LEN));
	assign load_res = (state_q == wssd_pkg::ST_RESULT) && (!res_valid_q || result.ready);

	assign sample.ready        = (state_q == wssd_pkg::ST_IDLE);
	assign result.valid        = res_valid_q;
	assign result.steady_flag  = res_steady_q;
	assign result.sample_taken = res_taken_q;
	assign result.drag_coeff   = res_cd_q;

	// remainder step: two step bits per cycle, MSB first
	always_comb begin
		mod_t = {rem_q, step_q[wssd_pkg::DATA_W-1 -: 2]};
		if (mod_t >= wssd_pkg::SI_X3) begin
			rem_d = wssd_pkg::R_W'(mod_t - wssd_pkg::SI_X3);
		end else if (mod_t >= wssd_pkg::SI_X2) begin
			rem_d = wssd_pkg::R_W'(mod_t - wssd_pkg::SI_X2);
		end else if (mod_t >= wssd_pkg::SI_X1) begin
			rem_d = wssd_pkg::R_W'(mod_t - wssd_pkg::SI_X1);
		end else begin
			rem_d = wssd_pkg::R_W'(mod_t);
		end
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			wssd_pkg::ST_MUL_LO: begin
				mul_a = $signed(wssd_pkg::MUL_A_W'(denom_q[wssd_pkg::DEN_LO_W-1:0]));
				mul_b = wssd_pkg::DATA_W'(rel_tol_q);
			end
			wssd_pkg::ST_MUL_HI: begin
				mul_a = $signed(wssd_pkg::MUL_A_W'(denom_q[wssd_pkg::MAG_W-1:wssd_pkg::DEN_LO_W]));
				mul_b = wssd_pkg::DATA_W'(rel_tol_q);
			end
			default: begin
				mul_a = wssd_pkg::MUL_A_W'(force_q);
				mul_b = cd_scale_q;
			end
		endcase
		mul_p = mul_a * $signed({1'b0, mul_b});
	end

	// floor shift and saturation of the scaled force
	always_comb begin
		shifted = prod_q[wssd_pkg::PROD_W-1:wssd_pkg::FRAC_SHIFT];
		if (shifted > $signed((wssd_pkg::PROD_W-wssd_pkg::FRAC_SHIFT)'(32'sh7FFF_FFFF))) begin
			cd_d = 32'sh7FFF_FFFF;
		end else if (shifted <
			$signed((wssd_pkg::PROD_W-wssd_pkg::FRAC_SHIFT)'(-33'sd2147483648))) begin
			cd_d = 32'sh8000_0000;
		end else begin
			cd_d = shifted[wssd_pkg::DATA_W-1:0];
		end
	end

	always_comb begin
		if (scan_cnt_q == wssd_pkg::CNT_W'(1)) begin
			scan_lo = rd_data_s1;
			scan_hi = rd_data_s1;
		end else begin
			scan_lo = (rd_data_s1 < lo_q) ? rd_data_s1 : lo_q;
			scan_hi = (rd_data_s1 > hi_q) ? rd_data_s1 : hi_q;
		end
	end

	always_comb begin
		span_ext  = {hi_q[wssd_pkg::DATA_W-1], hi_q} - {lo_q[wssd_pkg::DATA_W-1], lo_q};
		span_wl   = wssd_pkg::SUM_W'(span_ext[wssd_pkg::DATA_W-1:0]) *
			wssd_pkg::SUM_W'(wssd_pkg::WINDOW_LEN);
		mag       = sum_q[wssd_pkg::SUM_W-1] ? wssd_pkg::MAG_W'(-sum_q) : wssd_pkg::MAG_W'(sum_q);
		floor_tot = wssd_pkg::MAG_W'(avg_floor_q) * wssd_pkg::MAG_W'(wssd_pkg::WINDOW_LEN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wssd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			wssd_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = wssd_pkg::ST_MOD;
				end
			end
			wssd_pkg::ST_MOD: begin
				if (mod_cnt_q == wssd_pkg::MOD_CNT_W'(wssd_pkg::MOD_STEPS - 1)) begin
					state_d = wssd_pkg::ST_SAT;
				end
			end
			wssd_pkg::ST_SAT: begin
				if (take && (filled_q ||
					slot_q == wssd_pkg::SLOT_W'(wssd_pkg::WINDOW_LEN - 1))) begin
					state_d = wssd_pkg::ST_SCAN;
				end else begin
					state_d = wssd_pkg::ST_RESULT;
				end
			end
			wssd_pkg::ST_SCAN: begin
				if (scan_cnt_q == wssd_pkg::CNT_W'(wssd_pkg::WINDOW_LEN)) begin
					state_d = wssd_pkg::ST_SPAN;
				end
			end
			wssd_pkg::ST_SPAN:   state_d = wssd_pkg::ST_MUL_LO;
			wssd_pkg::ST_MUL_LO: state_d = wssd_pkg::ST_MUL_HI;
			wssd_pkg::ST_MUL_HI: state_d = wssd_pkg::ST_CMP;
			wssd_pkg::ST_CMP:    state_d = wssd_pkg::ST_RESULT;
			wssd_pkg::ST_RESULT: begin
				if (load_res) begin
					state_d = wssd_pkg::ST_IDLE;
				end
			end
			default: state_d = wssd_pkg::ST_IDLE;
		endcase
	end

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cd_scale_q  <= wssd_pkg::CD_SCALE_RST;
			rel_tol_q   <= wssd_pkg::REL_TOL_RST;
			avg_floor_q <= wssd_pkg::AVG_FLOOR_RST;
			slot_q      <= '0;
			filled_q    <= 1'b0;
			steady_q    <= 1'b0;
			mod_cnt_q   <= '0;
			scan_cnt_q  <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					wssd_pkg::REG_CD_SCALE:  cd_scale_q  <= cfg_data[wssd_pkg::DATA_W-1:0];
					wssd_pkg::REG_REL_TOL:   rel_tol_q   <= cfg_data[wssd_pkg::TOL_W-1:0];
					wssd_pkg::REG_AVG_FLOOR: avg_floor_q <= cfg_data[wssd_pkg::FLOOR_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				mod_cnt_q <= '0;
			end else if (state_q == wssd_pkg::ST_MOD) begin
				mod_cnt_q <= mod_cnt_q + 1'b1;
			end
			if (state_q == wssd_pkg::ST_SAT) begin
				scan_cnt_q <= '0;
				if (take) begin
					if (slot_q == wssd_pkg::SLOT_W'(wssd_pkg::WINDOW_LEN - 1)) begin
						slot_q   <= '0;
						filled_q <= 1'b1;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
			end else if (state_q == wssd_pkg::ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
			if (state_q == wssd_pkg::ST_CMP && lhs_q < rhs_q) begin
				steady_q <= 1'b1;
			end
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			step_q  <= sample.step_number;
			force_q <= sample.drag_force_sum;
			rem_q   <= '0;
		end else if (state_q == wssd_pkg::ST_MOD) begin
			step_q <= {step_q[wssd_pkg::DATA_W-3:0], 2'b00};
			rem_q  <= rem_d;
			prod_q <= mul_p[wssd_pkg::PROD_W-1:0];
		end
		if (state_q == wssd_pkg::ST_SAT) begin
			cd_q    <= cd_d;
			taken_q <= take;
		end
		if (state_q == wssd_pkg::ST_SCAN && scan_cnt_q != '0) begin
			lo_q <= scan_lo;
			hi_q <= scan_hi;
			if (scan_cnt_q == wssd_pkg::CNT_W'(1)) begin
				sum_q <= wssd_pkg::SUM_W'(rd_data_s1);
			end else begin
				sum_q <= sum_q + wssd_pkg::SUM_W'(rd_data_s1);
			end
		end
		if (state_q == wssd_pkg::ST_SPAN) begin
			lhs_q   <= {span_wl, {wssd_pkg::FRAC_SHIFT{1'b0}}};
			denom_q <= (mag > floor_tot) ? mag : floor_tot;
		end
		if (state_q == wssd_pkg::ST_MUL_LO) begin
			rhs_q <= mul_p[wssd_pkg::CMP_W-1:0];
		end else if (state_q == wssd_pkg::ST_MUL_HI) begin
			rhs_q <= rhs_q + (mul_p[wssd_pkg::CMP_W-1:0] << wssd_pkg::DEN_LO_W);
		end
		if (load_res) begin
			res_steady_q <= steady_q;
			res_taken_q  <= taken_q;
			res_cd_q     <= cd_q;
		end
	end

	// sample ring
	always_ff @(posedge clk) begin
		if (state_q == wssd_pkg::ST_SAT && take) begin
			ring[slot_q] <= cd_d;
		end
		if (ring_re) begin
			rd_data_s1 <= ring[scan_cnt_q[wssd_pkg::SLOT_W-1:0]];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/wssd_checker.sv
// ----------------------------------------------------------------------------
// wssd_checker: port-level checks of the windowed steady-state detector
// Watches the request channels and checks result hold, latched steady
// state and the busy period after each accepted request.
// ----------------------------------------------------------------------------
`default_nettype none

module wssd_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire out_valid,
	input wire out_ready,
	input wire out_steady,
	input wire out_taken
);

	logic seen_steady_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_steady_q <= 1'b0;
		end else if (out_valid && out_ready && out_steady) begin
			seen_steady_q <= 1'b1;
		end
	end

	hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	steady_stays: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_steady_q |-> out_steady)
		else $error("steady flag cleared after being reported");

	no_sample_after_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && seen_steady_q |-> !out_taken)
		else $error("sample taken after steady state");

	busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new request taken while busy");

endmodule

bind windowed_steady_state_detector_unit wssd_checker u_wssd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (sample.valid),
	.in_ready   (sample.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_steady (result.steady_flag),
	.out_taken  (result.sample_taken)
);

`default_nettype wire
